// ===== rtl/urtrb_pkg.sv =====
// Package for the serial receive/transmit ring buffer block.
// Holds event codes, field widths and the ring command/status structs.
// No dependencies.
package urtrb_pkg;

  localparam int BYTE_W   = 8;
  localparam int OP_W     = 3;
  localparam int FILL_W   = 8;
  localparam int CNT_W    = 32;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 152;

  // Event codes carried in the opcode field
  typedef enum logic [OP_W-1:0] {
    OP_LINE_RX    = 3'd0,
    OP_TX_READY   = 3'd1,
    OP_HOST_READ  = 3'd2,
    OP_HOST_WRITE = 3'd3,
    OP_FLUSH_RX   = 3'd4
  } opcode_t;

  // Command to one ring for one event
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_cmd_t;

  // Ring status from the current pointers
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [FILL_W-1:0] fill;
  } ring_stat_t;

endpackage

// ===== rtl/urtrb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while no read is issued. No dependencies.
module urtrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/urtrb_ring.sv =====
// One byte ring: read/write pointers around a urtrb_ram instance.
// Depends on urtrb_pkg and urtrb_ram.
module urtrb_ring
  import urtrb_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  ring_cmd_t         cmd,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata,
  output ring_stat_t        stat
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_EXT = (PW+1)'(DEPTH);

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_inc;
  logic [PW-1:0] rd_inc;
  logic [PW:0]   fill_raw;
  logic [31:0]   fill_wide;

  // pointer increment with wrap at the ring depth
  assign wr_inc = (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;

  // status from current pointers; fill saturates at 255
  assign fill_raw  = (wr_ptr >= rd_ptr) ? ({1'b0, wr_ptr} - {1'b0, rd_ptr})
                                        : ({1'b0, wr_ptr} + DEPTH_EXT - {1'b0, rd_ptr});
  assign fill_wide = 32'(fill_raw);
  assign stat.empty = (wr_ptr == rd_ptr);
  assign stat.full  = (wr_inc == rd_ptr);
  assign stat.fill  = (fill_wide > 32'd255) ? 8'hFF : fill_wide[FILL_W-1:0];

  // pointer update
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (cmd.flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= wr_inc;
      end
      if (cmd.pop) begin
        rd_ptr <= rd_inc;
      end
    end
  end

  urtrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_ptr),
    .wdata (wdata),
    .re    (cmd.pop),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

endmodule

// ===== rtl/uart_rx_tx_ring_buffers_unit.sv =====
// Top level of the serial receive/transmit ring buffer block.
// Depends on urtrb_pkg and urtrb_ring (which holds a urtrb_ram).
//
// Each input item is one event (line byte, transmitter ready, host read,
// host write, receive flush) and gives exactly one result item. Both rings
// live in synchronous RAMs with a registered read; a pop reads the entry in
// the accept cycle into the RAM read register, and the byte is captured into
// the output register when the event stage drains. An item is accepted in
// every cycle as long as the output side keeps up: the event stage drains
// into the output register in the same cycle that the next item enters.
// Each ring holds RING_DEPTH - 1 bytes. The stores need no clearing after
// reset.
module uart_rx_tx_ring_buffers_unit
  import urtrb_pkg::*;
#(
  parameter int RING_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  // s_tdata: [2:0] opcode, [10:3] data_byte, [15:11] zero
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  // m_tdata: [7:0] out_byte, [8] out_valid, [9] accepted, [17:10] rx_fill,
  // [18] tx_empty, [19] tx_irq_enable, [51:20] rx_byte_total,
  // [83:52] rx_drop_total, [115:84] tx_byte_total, [147:116] tx_drop_total,
  // [151:148] zero
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  opcode_t           op;
  logic [BYTE_W-1:0] data_byte;
  logic              accept;
  logic              load;

  ring_cmd_t         rx_cmd;
  ring_cmd_t         tx_cmd;
  ring_stat_t        rx_stat;
  ring_stat_t        tx_stat;
  logic [BYTE_W-1:0] rx_rdata;
  logic [BYTE_W-1:0] tx_rdata;

  logic              pend;
  logic              pend_ov;
  logic              pend_acc;
  logic              pend_tx;
  logic              ev_ov;
  logic              ev_acc;
  logic              ev_tx;

  logic              tx_irq;
  logic [CNT_W-1:0]  rx_cnt;
  logic [CNT_W-1:0]  rx_drop;
  logic [CNT_W-1:0]  tx_cnt;
  logic [CNT_W-1:0]  tx_drop;
  logic [BYTE_W-1:0] out_byte;

  assign op        = opcode_t'(s_tdata[OP_W-1:0]);
  assign data_byte = s_tdata[OP_W+BYTE_W-1:OP_W];

  // event stage drains into the output register when it is free
  assign load     = pend && (!m_tvalid || m_tready);
  assign s_tready = !pend || load;
  assign accept   = s_tvalid && s_tready;

  // decode one event into ring commands
  always_comb begin
    rx_cmd = '0;
    tx_cmd = '0;
    ev_ov  = 1'b0;
    ev_acc = 1'b0;
    ev_tx  = 1'b0;
    if (accept) begin
      case (op)
        OP_LINE_RX: begin
          rx_cmd.push = !rx_stat.full;
          ev_acc      = !rx_stat.full;
        end
        OP_TX_READY: begin
          tx_cmd.pop = !tx_stat.empty;
          ev_ov      = !tx_stat.empty;
          ev_tx      = 1'b1;
        end
        OP_HOST_READ: begin
          rx_cmd.pop = !rx_stat.empty;
          ev_ov      = !rx_stat.empty;
        end
        OP_HOST_WRITE: begin
          tx_cmd.push = !tx_stat.full;
          ev_acc      = !tx_stat.full;
        end
        OP_FLUSH_RX: begin
          rx_cmd.flush = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // irq flag and wrapping counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_irq  <= 1'b0;
      rx_cnt  <= '0;
      rx_drop <= '0;
      tx_cnt  <= '0;
      tx_drop <= '0;
    end else if (accept) begin
      case (op)
        OP_LINE_RX: begin
          if (rx_stat.full) begin
            rx_drop <= rx_drop + 1'b1;
          end else begin
            rx_cnt <= rx_cnt + 1'b1;
          end
        end
        OP_TX_READY: begin
          if (tx_stat.empty) begin
            tx_irq <= 1'b0;
          end else begin
            tx_cnt <= tx_cnt + 1'b1;
          end
        end
        OP_HOST_WRITE: begin
          if (tx_stat.full) begin
            tx_drop <= tx_drop + 1'b1;
          end else begin
            tx_irq <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // event stage: holds the event until the RAM read data is registered and the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (load) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ov  <= ev_ov;
      pend_acc <= ev_acc;
      pend_tx  <= ev_tx;
    end
  end

  assign out_byte = !pend_ov ? '0 : (pend_tx ? tx_rdata : rx_rdata);

  // output register; status reflects state right after the pending event
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'b0, tx_drop, tx_cnt, rx_drop, rx_cnt, tx_irq, tx_stat.empty,
                  rx_stat.fill, pend_acc, pend_ov, out_byte};
    end
  end

  urtrb_ring #(
    .DEPTH (RING_DEPTH)
  ) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rx_cmd),
    .wdata (data_byte),
    .rdata (rx_rdata),
    .stat  (rx_stat)
  );

  urtrb_ring #(
    .DEPTH (RING_DEPTH)
  ) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (tx_cmd),
    .wdata (data_byte),
    .rdata (tx_rdata),
    .stat  (tx_stat)
  );

endmodule

// ===== dv/tb_top.sv =====
// Testbench for uart_rx_tx_ring_buffers_unit: random and directed ring events.
// It predicts each result, compares it field by field and drives random stalls.
// Depends on urtrb_pkg and the RTL of the block.
module tb_top;
  import urtrb_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int FILL_MAX = (1 << FILL_W) - 1;
  localparam int RANDOM_EVENTS = 1450;
  // opcodes past the flush code are reserved and must leave the state alone
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_LAST = 3'd7;

  // s_tdata layout, lowest field last
  typedef struct packed {
    logic [S_DATA_W-BYTE_W-OP_W-1:0] pad;
    logic [BYTE_W-1:0]               data_byte;
    logic [OP_W-1:0]                 opcode;
  } event_t;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic [M_DATA_W-4*CNT_W-2*BYTE_W-4-1:0] pad;
    logic [CNT_W-1:0]  tx_drop_total;
    logic [CNT_W-1:0]  tx_byte_total;
    logic [CNT_W-1:0]  rx_drop_total;
    logic [CNT_W-1:0]  rx_byte_total;
    logic              tx_irq_enable;
    logic              tx_empty;
    logic [FILL_W-1:0] rx_fill;
    logic              accepted;
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
  } status_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  uart_rx_tx_ring_buffers_unit #(.RING_DEPTH(RING_DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // predicted ring state
  logic [BYTE_W-1:0] rx_ring [RING_DEPTH];
  logic [BYTE_W-1:0] tx_ring [RING_DEPTH];
  int                rx_wr = 0, rx_rd = 0, tx_wr = 0, tx_rd = 0;
  logic              tx_irq = 1'b0;
  logic [CNT_W-1:0]  rx_stored = '0, rx_dropped = '0, tx_sent = '0, tx_refused = '0;

  event_t  event_queue [$];
  status_t expected_status [$];
  event_t  cur_event;
  status_t want_status, got_status;
  int      n_events = 0;
  int      sent_cnt = 0;
  bit      failed = 1'b0;

  // apply one event to the predicted rings and return the status it yields
  function automatic status_t apply_event(event_t ev);
    status_t r;
    int nxt, fill;
    r = '0;
    case (ev.opcode)
      OP_LINE_RX: begin
        nxt = (rx_wr + 1) % RING_DEPTH;
        if (nxt != rx_rd) begin
          rx_ring[rx_wr] = ev.data_byte;
          rx_wr = nxt;
          rx_stored += 1;
          r.accepted = 1'b1;
        end else begin
          rx_dropped += 1;
        end
      end
      OP_TX_READY: begin
        if (tx_wr != tx_rd) begin
          r.out_byte = tx_ring[tx_rd];
          r.out_valid = 1'b1;
          tx_rd = (tx_rd + 1) % RING_DEPTH;
          tx_sent += 1;
        end else begin
          tx_irq = 1'b0;
        end
      end
      OP_HOST_READ: begin
        if (rx_wr != rx_rd) begin
          r.out_byte = rx_ring[rx_rd];
          r.out_valid = 1'b1;
          rx_rd = (rx_rd + 1) % RING_DEPTH;
        end
      end
      OP_HOST_WRITE: begin
        nxt = (tx_wr + 1) % RING_DEPTH;
        if (nxt != tx_rd) begin
          tx_ring[tx_wr] = ev.data_byte;
          tx_wr = nxt;
          tx_irq = 1'b1;
          r.accepted = 1'b1;
        end else begin
          tx_refused += 1;
        end
      end
      OP_FLUSH_RX: begin
        rx_wr = 0;
        rx_rd = 0;
      end
      default: ;
    endcase
    fill = (rx_wr - rx_rd + RING_DEPTH) % RING_DEPTH;
    r.rx_fill = (fill > FILL_MAX) ? FILL_MAX[FILL_W-1:0] : fill[FILL_W-1:0];
    r.tx_empty = (tx_wr == tx_rd);
    r.tx_irq_enable = tx_irq;
    r.rx_byte_total = rx_stored;
    r.rx_drop_total = rx_dropped;
    r.tx_byte_total = tx_sent;
    r.tx_drop_total = tx_refused;
    return r;
  endfunction

  // random stall, with a quiet stretch in the middle of the run
  function automatic bit take_break();
    bit quiet;
    quiet = (sent_cnt >= 500) && (sent_cnt < 800);
    return !quiet && ($urandom_range(0, 99) < 37);
  endfunction

  task automatic add_event(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
    event_t ev;
    ev = '0;
    ev.opcode = op;
    ev.data_byte = b;
    event_queue.push_back(ev);
  endtask

  // random data byte
  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // mostly valid ops, flush kept rare so the receive ring can build up
  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return OP_OP_RSVD();
    if (r < 9) return OP_FLUSH_RX;
    return OP_W'($urandom_range(OP_LINE_RX, OP_HOST_WRITE));
  endfunction

  function automatic logic [OP_W-1:0] OP_OP_RSVD();
    return OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // driver: present queued events, idling at random
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_status.push_back(apply_event(cur_event));
        sent_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (event_queue.size() > 0 && !take_break()) begin
          cur_event = event_queue.pop_front();
          s_tdata <= cur_event;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result item against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_status.size() == 0) begin
          $error("unexpected result item: %h", m_tdata);
          failed = 1'b1;
        end else begin
          want_status = expected_status.pop_front();
          got_status = m_tdata;
          check_field("out_byte", CNT_W'(want_status.out_byte),
                      CNT_W'(got_status.out_byte));
          check_field("out_valid", CNT_W'(want_status.out_valid),
                      CNT_W'(got_status.out_valid));
          check_field("accepted", CNT_W'(want_status.accepted),
                      CNT_W'(got_status.accepted));
          check_field("rx_fill", CNT_W'(want_status.rx_fill),
                      CNT_W'(got_status.rx_fill));
          check_field("tx_empty", CNT_W'(want_status.tx_empty),
                      CNT_W'(got_status.tx_empty));
          check_field("tx_irq_enable", CNT_W'(want_status.tx_irq_enable),
                      CNT_W'(got_status.tx_irq_enable));
          check_field("rx_byte_total", want_status.rx_byte_total,
                      got_status.rx_byte_total);
          check_field("rx_drop_total", want_status.rx_drop_total,
                      got_status.rx_drop_total);
          check_field("tx_byte_total", want_status.tx_byte_total,
                      got_status.tx_byte_total);
          check_field("tx_drop_total", want_status.tx_drop_total,
                      got_status.tx_drop_total);
        end
      end
      m_tready <= !take_break();
    end
  end

  // stimulus, reset and end of run
  initial begin
    int first_random, seg_len, kind, seg, i;
    // directed: empty pops, extremes of the byte, flush, reserved codes
    add_event(OP_HOST_READ, 8'h00);
    add_event(OP_TX_READY, 8'hFF);
    add_event(OP_HOST_WRITE, 8'h00);
    add_event(OP_HOST_WRITE, 8'hFF);
    add_event(OP_TX_READY, 8'h00);
    add_event(OP_FLUSH_RX, 8'h00);
    add_event(OP_LINE_RX, 8'h00);
    add_event(OP_LINE_RX, 8'hFF);
    add_event(OP_LINE_RX, 8'hA5);
    add_event(OP_HOST_READ, 8'hFF);
    add_event(OP_FLUSH_RX, 8'hFF);
    add_event(OP_HOST_READ, 8'h00);
    add_event(OP_RSVD_FIRST, 8'hFF);
    add_event(OP_RSVD_MID, 8'h5A);
    add_event(OP_RSVD_LAST, 8'hFF);
    add_event(OP_TX_READY, 8'hFF);
    // empty transmit ring with the enable set clears it
    add_event(OP_TX_READY, 8'h00);
    add_event(OP_HOST_WRITE, 8'h5A);
    add_event(OP_LINE_RX, 8'h3C);
    add_event(OP_TX_READY, 8'h00);
    add_event(OP_HOST_READ, 8'h00);
    first_random = event_queue.size();

    // random segments: floods fill a ring to full, drains pop from both rings, mixes wander
    seg = 0;
    while (event_queue.size() < first_random + RANDOM_EVENTS) begin
      kind = (seg < 3) ? seg : $urandom_range(0, 9);
      case (kind)
        0, 3: begin
          seg_len = $urandom_range(290, 320);
          for (i = 0; i < seg_len && event_queue.size() < first_random + RANDOM_EVENTS; i++)
            if ($urandom_range(0, 19) == 0) add_event(OP_HOST_READ, rand_byte());
            else add_event(OP_LINE_RX, rand_byte());
        end
        1, 4: begin
          seg_len = $urandom_range(290, 320);
          for (i = 0; i < seg_len && event_queue.size() < first_random + RANDOM_EVENTS; i++)
            if ($urandom_range(0, 19) == 0) add_event(OP_TX_READY, rand_byte());
            else add_event(OP_HOST_WRITE, rand_byte());
        end
        2, 5: begin
          seg_len = $urandom_range(40, 280);
          for (i = 0; i < seg_len && event_queue.size() < first_random + RANDOM_EVENTS; i++)
            if ($urandom_range(0, 1)) add_event(OP_TX_READY, rand_byte());
            else add_event(OP_HOST_READ, rand_byte());
        end
        default: begin
          seg_len = $urandom_range(10, 60);
          for (i = 0; i < seg_len && event_queue.size() < first_random + RANDOM_EVENTS; i++)
            add_event(pick_op(), rand_byte());
        end
      endcase
      seg++;
    end
    n_events = event_queue.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (sent_cnt == n_events && expected_status.size() == 0);
    repeat (16) @(posedge clk);
    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/urtrb_pkg.sv
rtl/urtrb_ram.sv
rtl/urtrb_ring.sv
rtl/uart_rx_tx_ring_buffers_unit.sv
dv/tb_top.sv
